### src/bgm_pkg.sv
package bgm_pkg;

   typedef enum logic [2:0] {
      MODE_RUN  = 3'd0,
      MODE_SP   = 3'd1,
      MODE_MENU = 3'd2,
      MODE_KP   = 3'd3,
      MODE_KI   = 3'd4,
      MODE_KD   = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      CSR_LONG_PRESS   = 3'd0,
      CSR_DOUBLE_CLICK = 3'd1,
      CSR_BLINK        = 3'd2,
      CSR_INIT_SP      = 3'd3,
      CSR_INIT_FAN     = 3'd4,
      CSR_INIT_KP      = 3'd5,
      CSR_INIT_KI      = 3'd6,
      CSR_INIT_KD      = 3'd7
   } csr_index_type;

   localparam logic [15:0] LONG_PRESS_RST   = 16'd500;
   localparam logic [15:0] DOUBLE_CLICK_RST = 16'd300;
   localparam logic [15:0] BLINK_RST        = 16'd500;
   localparam logic [8:0]  INIT_SP_RST      = 9'd250;
   localparam logic [6:0]  INIT_FAN_RST     = 7'd100;
   localparam logic [15:0] INIT_GAIN_RST    = 16'd0;

   localparam logic signed [8:0]  FAN_MIN = 9'sd20;
   localparam logic signed [8:0]  FAN_MAX = 9'sd100;
   localparam logic signed [10:0] SP_MIN  = 11'sd50;
   localparam logic signed [10:0] SP_MAX  = 11'sd450;
   localparam logic signed [17:0] GAIN_MAX = 18'sd65535;

   function automatic mode_type single_next(input mode_type m, input logic [1:0] sel);
      mode_type r;
      case (m)
         MODE_RUN:  r = MODE_SP;
         MODE_SP:   r = MODE_RUN;
         MODE_MENU: r = (sel == 2'd0) ? MODE_KP : (sel == 2'd1) ? MODE_KI : MODE_KD;
         default:   r = MODE_MENU;
      endcase
      return r;
   endfunction

   function automatic mode_type double_next(input mode_type m);
      mode_type r;
      case (m)
         MODE_RUN:           r = MODE_MENU;
         MODE_SP, MODE_MENU: r = MODE_RUN;
         default:            r = MODE_MENU;
      endcase
      return r;
   endfunction

   function automatic mode_type long_next(input mode_type m);
      mode_type r;
      case (m)
         MODE_RUN:           r = MODE_RUN;
         MODE_SP, MODE_MENU: r = MODE_RUN;
         default:            r = MODE_MENU;
      endcase
      return r;
   endfunction

endpackage

### src/button_gesture_menu_controller_unit.sv
// Button gesture and menu controller. Each req word is one millisecond tick
// (button level plus signed encoder detents); each tick yields exactly one rsp
// word with the menu mode, edited values and this tick's pulses. A tick is taken
// every clock cycle while the rsp register is empty or being drained, and its
// result is in the rsp register from the next cycle on; there is a single result
// register, and the unit keeps accepting while the far side drains it. csr writes
// to the initial_* registers also load the live setpoint, fan or gain at once.
module button_gesture_menu_controller_unit
   import bgm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] button_level, [5:1] encoder_steps, [7:6] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] ui_mode, [4:3] gain_choice, [13:5] setpoint_value, [20:14] fan_percent,
   // [36:21] kp_value, [52:37] ki_value, [68:53] kd_value, [69] blink_on,
   // [70] setpoint_commit, [71] fan_update, [72] gain_update, [79:73] zero
   output logic [79:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic [15:0] long_press_ff, double_click_ff, blink_ticks_ff;
   logic [31:0] tick_ff, press_start_ff, last_click_ff, last_toggle_ff;
   logic [31:0] press_start_in, last_click_in, last_toggle_in;
   logic        button_prev_ff, pending_ff, pending_in, blink_ff, blink_in;
   mode_type    mode_ff, mode_in;
   logic [1:0]  sel_ff, sel_in;
   logic [8:0]  sp_ff, sp_in;
   logic [6:0]  fan_ff, fan_in;
   logic [15:0] kp_ff, ki_ff, kd_ff, kp_in, ki_in, kd_in;
   logic        rsp_valid_ff;
   logic [79:0] rsp_data_ff, rsp_data_in;

   logic        accept, level, commit, fan_pulse, gain_pulse, single_fire;
   logic signed [4:0] steps;
   mode_type    mode_mid;
   logic        pending_mid;

   assign accept     = req_tvalid & req_tready;
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign level      = req_tdata[0];
   assign steps      = $signed(req_tdata[5:1]);

   // gesture decode and mode transitions
   always_comb begin
      logic [31:0] now, press_len, click_age;
      now            = tick_ff;
      press_len      = now - press_start_ff;
      click_age      = now - last_click_ff;
      press_start_in = press_start_ff;
      last_click_in  = last_click_ff;
      pending_mid    = pending_ff;
      mode_mid       = mode_ff;
      commit         = 1'b0;
      if (level && !button_prev_ff) begin
         press_start_in = now;
      end else if (!level && button_prev_ff) begin
         if (press_len < {16'd0, long_press_ff}) begin
            if (pending_ff && click_age < {16'd0, double_click_ff}) begin
               pending_mid = 1'b0;
               mode_mid    = double_next(mode_ff);
            end else begin
               pending_mid   = 1'b1;
               last_click_in = now;
            end
         end else begin
            commit   = (mode_ff == MODE_SP);
            mode_mid = long_next(mode_ff);
         end
      end
      // pending click older than the window becomes a single click
      single_fire = pending_mid && ((now - last_click_in) > {16'd0, double_click_ff});
      pending_in  = pending_mid & ~single_fire;
      mode_in     = mode_mid;
      if (single_fire) begin
         if (mode_mid == MODE_SP) commit = 1'b1;
         mode_in = single_next(mode_mid, sel_ff);
      end
   end

   // encoder edits in the resulting mode, blink
   always_comb begin
      logic signed [7:0]  steps8, mul5;
      logic signed [8:0]  mul10, fan_sum;
      logic signed [10:0] sp_sum;
      logic signed [17:0] gain_sum, gain_inc;
      logic [15:0]        gain_cur;
      logic [5:0]         sel_x, sel_r;
      logic [11:0]        sel_prod;
      logic [4:0]         sel_q;
      logic [31:0]        toggle_age;
      steps8   = {{3{steps[4]}}, steps};
      mul5     = (steps8 <<< 2) + steps8;
      mul10    = {mul5[7], mul5} <<< 1;
      fan_sum  = $signed({2'b00, fan_ff}) + {mul5[7], mul5};
      sp_sum   = $signed({2'b00, sp_ff}) + {{3{mul5[7]}}, mul5};
      // (sel + steps + 18) mod 3 via reciprocal 43/128, exact below 64
      sel_x    = 6'(7'({5'd0, sel_ff}) + 7'({{2{steps[4]}}, steps}) + 7'd18);
      sel_prod = 12'(sel_x) * 12'd43;
      sel_q    = sel_prod[11:7];
      sel_r    = sel_x - 6'(sel_q) * 6'd3;
      case (mode_in)
         MODE_KP: gain_cur = kp_ff;
         MODE_KI: gain_cur = ki_ff;
         default: gain_cur = kd_ff;
      endcase
      gain_inc = (mode_in == MODE_KP) ? {{9{mul10[8]}}, mul10} : {{13{steps[4]}}, steps};
      gain_sum = $signed({2'b00, gain_cur}) + gain_inc;
      if (gain_sum < 0) gain_sum = '0;
      else if (gain_sum > GAIN_MAX) gain_sum = GAIN_MAX;
      if (fan_sum < FAN_MIN) fan_sum = FAN_MIN;
      else if (fan_sum > FAN_MAX) fan_sum = FAN_MAX;
      if (sp_sum < SP_MIN) sp_sum = SP_MIN;
      else if (sp_sum > SP_MAX) sp_sum = SP_MAX;

      sel_in     = sel_ff;
      sp_in      = sp_ff;
      fan_in     = fan_ff;
      kp_in      = kp_ff;
      ki_in      = ki_ff;
      kd_in      = kd_ff;
      fan_pulse  = 1'b0;
      gain_pulse = 1'b0;
      if (steps != 5'sd0) begin
         case (mode_in)
            MODE_RUN: begin
               fan_in    = fan_sum[6:0];
               fan_pulse = 1'b1;
            end
            MODE_SP:   sp_in  = sp_sum[8:0];
            MODE_MENU: sel_in = sel_r[1:0];
            MODE_KP: begin
               kp_in      = gain_sum[15:0];
               gain_pulse = 1'b1;
            end
            MODE_KI: begin
               ki_in      = gain_sum[15:0];
               gain_pulse = 1'b1;
            end
            MODE_KD: begin
               kd_in      = gain_sum[15:0];
               gain_pulse = 1'b1;
            end
            default: ;
         endcase
      end

      toggle_age     = tick_ff - last_toggle_ff;
      last_toggle_in = last_toggle_ff;
      blink_in       = blink_ff;
      if (toggle_age > {16'd0, blink_ticks_ff}) begin
         last_toggle_in = tick_ff;
         blink_in       = ~blink_ff;
      end

      rsp_data_in = {7'd0, gain_pulse, fan_pulse, commit, blink_in, kd_in, ki_in, kp_in,
                     fan_in, sp_in, sel_in, mode_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff   <= LONG_PRESS_RST;
         double_click_ff <= DOUBLE_CLICK_RST;
         blink_ticks_ff  <= BLINK_RST;
         tick_ff         <= '0;
         press_start_ff  <= '0;
         last_click_ff   <= '0;
         last_toggle_ff  <= '0;
         button_prev_ff  <= 1'b0;
         pending_ff      <= 1'b0;
         blink_ff        <= 1'b0;
         mode_ff         <= MODE_RUN;
         sel_ff          <= '0;
         sp_ff           <= INIT_SP_RST;
         fan_ff          <= INIT_FAN_RST;
         kp_ff           <= INIT_GAIN_RST;
         ki_ff           <= INIT_GAIN_RST;
         kd_ff           <= INIT_GAIN_RST;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (accept) begin
            tick_ff        <= tick_ff + 32'd1;
            press_start_ff <= press_start_in;
            last_click_ff  <= last_click_in;
            last_toggle_ff <= last_toggle_in;
            button_prev_ff <= level;
            pending_ff     <= pending_in;
            blink_ff       <= blink_in;
            mode_ff        <= mode_in;
            sel_ff         <= sel_in;
            sp_ff          <= sp_in;
            fan_ff         <= fan_in;
            kp_ff          <= kp_in;
            ki_ff          <= ki_in;
            kd_ff          <= kd_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            case (csr_index_type'(csr_index))
               CSR_LONG_PRESS:   long_press_ff   <= csr_data;
               CSR_DOUBLE_CLICK: double_click_ff <= csr_data;
               CSR_BLINK:        blink_ticks_ff  <= csr_data;
               CSR_INIT_SP:      sp_ff           <= csr_data[8:0];
               CSR_INIT_FAN:     fan_ff          <= csr_data[6:0];
               CSR_INIT_KP:      kp_ff           <= csr_data;
               CSR_INIT_KI:      ki_ff           <= csr_data;
               CSR_INIT_KD:      kd_ff           <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) rsp_data_ff <= rsp_data_in;
   end

endmodule

### test/bgm_panel_checker.sv
`timescale 1ns / 100ps

module bgm_panel_checker
   import bgm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] button_level, [5:1] encoder_steps, [7:6] zero
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] ui_mode, [4:3] gain_choice, [13:5] setpoint_value, [20:14] fan_percent,
   // [36:21] kp_value, [52:37] ki_value, [68:53] kd_value, [69] blink_on,
   // [70] setpoint_commit, [71] fan_update, [72] gain_update, [79:73] zero
   input  logic [79:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          mismatch_count,
   output int          ticks_pending,
   output int          ticks_checked
);

   // same bit layout as rsp_tdata[72:0]
   typedef struct packed {
      logic        gain_upd;
      logic        fan_upd;
      logic        commit;
      logic        blink;
      logic [15:0] kd;
      logic [15:0] ki;
      logic [15:0] kp;
      logic [6:0]  fan;
      logic [8:0]  setpoint;
      logic [1:0]  choice;
      logic [2:0]  mode;
   } panel_word_type;

   typedef enum logic [1:0] {
      GEST_SINGLE,
      GEST_DOUBLE,
      GEST_LONG
   } gesture_type;

   localparam int FAN_LO    = 20;
   localparam int FAN_HI    = 100;
   localparam int SP_LO     = 50;
   localparam int SP_HI     = 450;
   localparam int GAIN_TOP  = 65535;
   localparam int DETENT    = 5;
   localparam int KP_DETENT = 10;

   logic [15:0] long_limit, dbl_window, blink_period;
   logic [8:0]  sp_init;
   logic [6:0]  fan_init;
   logic [15:0] gain_init [3];

   logic [31:0] tick_now, press_t0, click_t, toggle_t;
   logic        level_q, click_armed, blink_q, commit_hit;
   mode_type    mode_q;
   logic [1:0]  choice_q;
   logic [8:0]  setpoint_q;
   logic [6:0]  fan_q;
   logic [15:0] gain_q [3];

   panel_word_type predicted_panels [$];
   int errs = 0;
   int seen = 0;

   function automatic int clip(input int v, input int lo, input int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   task automatic reset_panel();
      long_limit   = LONG_PRESS_RST;
      dbl_window   = DOUBLE_CLICK_RST;
      blink_period = BLINK_RST;
      sp_init      = INIT_SP_RST;
      fan_init     = INIT_FAN_RST;
      for (int i = 0; i < 3; i++) begin
         gain_init[i] = INIT_GAIN_RST;
         gain_q[i]    = gain_init[i];
      end
      tick_now    = '0;
      press_t0    = '0;
      click_t     = '0;
      toggle_t    = '0;
      level_q     = 1'b0;
      click_armed = 1'b0;
      blink_q     = 1'b0;
      mode_q      = MODE_RUN;
      choice_q    = '0;
      setpoint_q  = sp_init;
      fan_q       = fan_init;
   endtask

   task automatic apply_csr();
      case (csr_index)
         CSR_LONG_PRESS:   long_limit   = csr_data;
         CSR_DOUBLE_CLICK: dbl_window   = csr_data;
         CSR_BLINK:        blink_period = csr_data;
         CSR_INIT_SP: begin
            sp_init    = csr_data[8:0];
            setpoint_q = sp_init;
         end
         CSR_INIT_FAN: begin
            fan_init = csr_data[6:0];
            fan_q    = fan_init;
         end
         CSR_INIT_KP, CSR_INIT_KI, CSR_INIT_KD: begin
            gain_init[2'(csr_index - CSR_INIT_KP)] = csr_data;
            gain_q[2'(csr_index - CSR_INIT_KP)]    = csr_data;
         end
         default: ;
      endcase
   endtask

   task automatic take_gesture(input gesture_type kind);
      case (mode_q)
         MODE_RUN: begin
            if (kind == GEST_SINGLE) mode_q = MODE_SP;
            else if (kind == GEST_DOUBLE) mode_q = MODE_MENU;
         end
         MODE_SP: begin
            if (kind != GEST_DOUBLE) commit_hit = 1'b1;
            mode_q = MODE_RUN;
         end
         MODE_MENU: begin
            if (kind != GEST_SINGLE) mode_q = MODE_RUN;
            else if (choice_q == 2'd0) mode_q = MODE_KP;
            else if (choice_q == 2'd1) mode_q = MODE_KI;
            else mode_q = MODE_KD;
         end
         default: mode_q = MODE_MENU;
      endcase
   endtask

   task automatic advance_panel(input logic lvl, input logic signed [4:0] st5);
      panel_word_type w;
      int st, acc, gi;
      logic fan_hit, gain_hit;
      st = int'(st5);
      fan_hit = 1'b0;
      gain_hit = 1'b0;
      commit_hit = 1'b0;

      if (lvl && !level_q) begin
         press_t0 = tick_now;
      end else if (!lvl && level_q) begin
         if (tick_now - press_t0 < long_limit) begin
            if (click_armed && tick_now - click_t < dbl_window) begin
               click_armed = 1'b0;
               take_gesture(GEST_DOUBLE);
            end else begin
               click_armed = 1'b1;
               click_t = tick_now;
            end
         end else begin
            take_gesture(GEST_LONG);
         end
      end
      level_q = lvl;

      // first click left alone past the window becomes a single click
      if (click_armed && tick_now - click_t > dbl_window) begin
         click_armed = 1'b0;
         take_gesture(GEST_SINGLE);
      end

      if (st != 0) begin
         case (mode_q)
            MODE_RUN: begin
               acc = int'(fan_q) + st * DETENT;
               fan_q = 7'(clip(acc, FAN_LO, FAN_HI));
               fan_hit = 1'b1;
            end
            MODE_SP: begin
               acc = int'(setpoint_q) + st * DETENT;
               setpoint_q = 9'(clip(acc, SP_LO, SP_HI));
            end
            MODE_MENU: begin
               acc = (int'(choice_q) + st) % 3;
               if (acc < 0) acc += 3;
               choice_q = 2'(acc);
            end
            default: begin
               gi = int'(mode_q) - int'(MODE_KP);
               acc = int'(gain_q[gi]) + ((mode_q == MODE_KP) ? st * KP_DETENT : st);
               gain_q[gi] = 16'(clip(acc, 0, GAIN_TOP));
               gain_hit = 1'b1;
            end
         endcase
      end

      if (tick_now - toggle_t > blink_period) begin
         toggle_t = tick_now;
         blink_q = !blink_q;
      end
      tick_now = tick_now + 32'd1;

      w.mode     = mode_q;
      w.choice   = choice_q;
      w.setpoint = setpoint_q;
      w.fan      = fan_q;
      w.kp       = gain_q[0];
      w.ki       = gain_q[1];
      w.kd       = gain_q[2];
      w.blink    = blink_q;
      w.commit   = commit_hit;
      w.fan_upd  = fan_hit;
      w.gain_upd = gain_hit;
      predicted_panels.push_back(w);
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         if (errs < 10)
            $display("rsp word %0d: %s expected %0d, got %0d", seen, name, want, got);
         errs++;
      end
   endtask

   task automatic check_word();
      panel_word_type got, want;
      got = rsp_tdata[72:0];
      seen++;
      if (predicted_panels.size() == 0) begin
         if (errs < 10) $display("rsp word %0d arrived with no tick outstanding", seen);
         errs++;
      end else begin
         want = predicted_panels.pop_front();
         check_field("ui_mode", want.mode, got.mode);
         check_field("gain_choice", want.choice, got.choice);
         check_field("setpoint_value", want.setpoint, got.setpoint);
         check_field("fan_percent", want.fan, got.fan);
         check_field("kp_value", want.kp, got.kp);
         check_field("ki_value", want.ki, got.ki);
         check_field("kd_value", want.kd, got.kd);
         check_field("blink_on", want.blink, got.blink);
         check_field("setpoint_commit", want.commit, got.commit);
         check_field("fan_update", want.fan_upd, got.fan_upd);
         check_field("gain_update", want.gain_upd, got.gain_upd);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         reset_panel();
         predicted_panels.delete();
      end else begin
         if (csr_valid && csr_ready) apply_csr();
         // a word leaving now was predicted at an earlier edge, so check first
         if (rsp_tvalid && rsp_tready) check_word();
         if (req_tvalid && req_tready) advance_panel(req_tdata[0], req_tdata[5:1]);
      end
      mismatch_count <= errs;
      ticks_pending  <= predicted_panels.size();
      ticks_checked  <= seen;
   end

endmodule

### test/tb_button_gesture_menu_controller_unit.sv
`timescale 1ns / 100ps

module tb_button_gesture_menu_controller_unit;
   import bgm_pkg::*;

   typedef struct packed {
      logic signed [4:0] steps;
      logic              lvl;
   } tick_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   int mismatch_count, ticks_pending, ticks_checked;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_ask = 0;
   int settings_used = 0;
   int long_cfg = int'(LONG_PRESS_RST);
   int dbl_cfg = int'(DOUBLE_CLICK_RST);
   tick_type burst_q [$];

   button_gesture_menu_controller_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   bgm_panel_checker u_panel_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .ticks_pending  (ticks_pending),
      .ticks_checked  (ticks_checked)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // rsp side: random stalls, plus a long hold-off when hold_ask is set
   initial begin : rsp_sink
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_ask > 0) begin
            hold_left = hold_ask;
            hold_ask = 0;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   task automatic send_tick(input tick_type t);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, t};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic play_burst();
      while (burst_q.size() != 0) send_tick(burst_q.pop_front());
   endtask

   // stop offering ticks and wait until every predicted word came back
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (ticks_pending != 0) @(posedge clock);
   endtask

   task automatic csr_put(input csr_index_type idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic write_settings(input logic [15:0] lp, dc, bl, sp, fan, kp, ki, kd);
      csr_put(CSR_LONG_PRESS, lp);
      csr_put(CSR_DOUBLE_CLICK, dc);
      csr_put(CSR_BLINK, bl);
      csr_put(CSR_INIT_SP, sp);
      csr_put(CSR_INIT_FAN, fan);
      csr_put(CSR_INIT_KP, kp);
      csr_put(CSR_INIT_KI, ki);
      csr_put(CSR_INIT_KD, kd);
      csr_valid <= 1'b0;
      long_cfg = int'(lp);
      dbl_cfg = int'(dc);
      settings_used++;
   endtask

   function automatic logic [15:0] rnd_gain();
      case ($urandom_range(2))
         0:       return 16'($urandom_range(40));
         1:       return 16'($urandom_range(65535, 65500));
         default: return 16'($urandom_range(65535));
      endcase
   endfunction

   function automatic int rnd_steps();
      return ($urandom_range(99) < 55) ? 0 : int'($urandom_range(31));
   endfunction

   function automatic int capped(input int v);
      return (v > 16) ? 16 : v;
   endfunction

   function automatic int short_len(input int lp);
      return (lp <= 1) ? 1 : int'($urandom_range(capped(lp - 1), 1));
   endfunction

   task automatic add_tick(input logic lvl, input int st);
      tick_type t;
      t.lvl = lvl;
      t.steps = st[4:0];
      burst_q.push_back(t);
   endtask

   task automatic queue_press(input int len);
      repeat (len) add_tick(1'b1, rnd_steps());
      add_tick(1'b0, rnd_steps());
   endtask

   task automatic queue_idle(input int len);
      repeat (len) add_tick(1'b0, rnd_steps());
   endtask

   task automatic queue_gesture();
      int lp, dc;
      lp = long_cfg;
      dc = dbl_cfg;
      case ($urandom_range(9))
         0, 1, 2: begin
            queue_press(short_len(lp));
            queue_idle($urandom_range(capped(dc + 3), 0));
         end
         3, 4: begin
            queue_press(short_len(lp));
            queue_idle($urandom_range(capped(dc + 1), 0));
            queue_press(short_len(lp));
         end
         5: begin
            if (lp <= 40) queue_press($urandom_range(lp + 3, (lp < 1) ? 1 : lp));
            else queue_press(short_len(lp));
         end
         6, 7: queue_idle($urandom_range(8, 1));
         8: repeat ($urandom_range(6, 1)) add_tick(1'($urandom_range(1)), rnd_steps());
         default: queue_idle($urandom_range(capped(dc + 4), 1));
      endcase
   endtask

   task automatic run_random(input int count);
      int done;
      done = 0;
      while (done < count) begin
         queue_gesture();
         done += burst_q.size();
         play_burst();
      end
   endtask

   initial begin : stimulus
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // short timings and extreme start values for the directed walk
      write_settings(16'd4, 16'd3, 16'd1, 16'd50, 16'd20, 16'd65535, 16'd0, 16'd65530);
      add_tick(1'b0, -16);                      // fan clamps at the bottom
      add_tick(1'b0, 15);
      add_tick(1'b1, 0);                        // click, then let the window run out
      repeat (4) add_tick(1'b0, 0);
      add_tick(1'b0, -16);                      // single fired: setpoint edit, low clamp
      repeat (4) add_tick(1'b1, 15);            // long press in setpoint edit commits
      add_tick(1'b0, 15);
      add_tick(1'b1, 0);                        // double click into the gain menu
      add_tick(1'b0, 0);
      add_tick(1'b1, 0);
      add_tick(1'b0, 0);
      add_tick(1'b0, -16);                      // selection wraps below zero
      add_tick(1'b1, 0);
      repeat (4) add_tick(1'b0, 0);
      add_tick(1'b0, 15);                       // kd edit, saturates at the top
      add_tick(1'b0, -16);
      play_burst();

      // zero timing: every release is a long press, no double click
      settle();
      write_settings(16'd0, 16'd0, 16'd65535, 16'd450, 16'd100, 16'd0, 16'd65535, 16'd0);
      run_random(40);

      // widest timing: no long press reachable, single click never times out
      settle();
      write_settings(16'd65535, 16'd65535, 16'd2, 16'd250, 16'd60, rnd_gain(), rnd_gain(),
                     rnd_gain());
      run_random(60);

      for (int ph = 0; ph < 4; ph++) begin
         settle();
         case (ph)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 67; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 67; end
            default: begin send_idle_pct = 11; rsp_stall_pct = 11; end
         endcase
         write_settings(16'($urandom_range(12, 2)), 16'($urandom_range(8, 1)),
                        16'($urandom_range(20, 1)), 16'($urandom_range(450, 50)),
                        16'($urandom_range(100, 20)), rnd_gain(), rnd_gain(), rnd_gain());
         if (ph == 0) begin
            run_random(70);
            hold_ask = 150;   // sink holds off while ticks keep coming
            run_random(130);
         end else if (ph == 3) begin
            run_random(100);
            settle();
            run_random(100);
         end else begin
            run_random(200);
         end
      end

      settle();
      repeat (10) @(posedge clock);
      $display("covered %0d ticks under %0d register settings and four idle/stall mixes",
               ticks_checked, settings_used);
      $display("gestures: clicks, double clicks, long presses, clamps, wraps, saturation");
      if (mismatch_count == 0 && ticks_pending == 0) begin
         $display("button_gesture_menu_controller_unit test passed");
      end else begin
         $display("button_gesture_menu_controller_unit test failed");
      end
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("button_gesture_menu_controller_unit test failed");
      $finish;
   end

endmodule
